// ===== hdl/wsfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wsfp_pkg;

	localparam int unsigned LenW       = 63;
	localparam int unsigned QueueDepth = 4;

	// Fixed header codes of the frame format
	localparam logic [6:0] Len7Ext16 = 7'h7e;
	localparam logic [6:0] Len7Ext64 = 7'h7f;
	localparam logic [3:0] ExtBytes16 = 4'd2;
	localparam logic [3:0] ExtBytes64 = 4'd8;
	localparam logic [3:0] KeyBytes   = 4'd4;

	// Result kinds
	localparam logic KindHeader  = 1'b0;
	localparam logic KindPayload = 1'b1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       buffer_start;
	} item_t;

	typedef struct packed {
		logic            kind;
		logic            final_fragment;
		logic [2:0]      reserved_bits;
		logic [3:0]      opcode;
		logic            is_masked;
		logic [LenW-1:0] payload_length;
		logic [7:0]      payload_byte;
		logic            end_of_frame;
	} result_t;

	// One classified beat handed from the parser to the output side
	typedef struct packed {
		logic            kind;
		logic            final_fragment;
		logic [2:0]      reserved_bits;
		logic [3:0]      opcode;
		logic            is_masked;
		logic [LenW-1:0] payload_length;
		logic [7:0]      raw_byte;
		logic [7:0]      key_byte;
		logic            end_of_frame;
	} entry_t;

endpackage
`default_nettype wire

// ===== hdl/websocket_frame_parser_unit.sv =====
// WebSocket (RFC 6455) receive frame parser. Feed the received stream one
// byte per beat, with buffer_start set on the first byte of each buffer to
// restart at the frame header. The unit returns one header beat once the
// length and optional masking key are in, then one beat per payload byte,
// already unmasked, with end_of_frame on the last beat of the frame; bytes
// after the payload are dropped. It takes one byte per clock while item_stall is low: the parser
// classifies a byte in the cycle it is accepted, and a result then passes through
// the internal queue and the output register before it reaches the output.
// Input stall rises only when the queue (QUEUE_DEPTH entries) is full, which
// happens when the output side stalls while result-producing bytes keep coming.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_parser_unit #(
	parameter int unsigned QUEUE_DEPTH = wsfp_pkg::QueueDepth
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire wsfp_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output wsfp_pkg::result_t      result
);

	wsfp_pkg::entry_t wr_entry, rd_entry;
	logic             take, rd_valid, pop;
	logic             q_push, q_full;

	assign item_stall = q_full;
	assign take       = item_valid && !q_full;

	// Parser
	wsfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.push   (q_push),
		.entry  (wr_entry)
	);

	// Decoupling queue
	wsfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry),
		.full     (q_full)
	);

	// Output stage
	wsfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (rd_valid),
		.rd_entry     (rd_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== hdl/wsfp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire wsfp_pkg::item_t item,
	output logic                 push,
	output wsfp_pkg::entry_t     entry
);

	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	phase_t                      phase_q, phase_cur, phase_nx;
	logic                        fin_q;
	logic [2:0]                  rsv_q;
	logic [3:0]                  opcode_q;
	logic                        masked_q, masked_nx;
	logic [wsfp_pkg::LenW-1:0]   len_q, len_nx;
	logic [wsfp_pkg::LenW-1:0]   rem_q, rem_nx;
	logic [3:0]                  cnt_q, cnt_nx;
	logic [31:0]                 key_q, key_nx;
	logic [1:0]                  idx_q, idx_nx;
	logic [7:0]                  b;
	logic [wsfp_pkg::LenW-1:0]   ext_len;
	logic                        len_done;
	logic [wsfp_pkg::LenW-1:0]   done_len;

	assign b         = item.byte_value;
	assign phase_cur = item.buffer_start ? PH_HDR1 : phase_q;
	assign ext_len   = {len_q[wsfp_pkg::LenW-9:0], b};

	// Next-state and beat classification
	always_comb begin
		phase_nx  = phase_cur;
		masked_nx = masked_q;
		len_nx    = len_q;
		rem_nx    = rem_q;
		cnt_nx    = cnt_q;
		key_nx    = key_q;
		idx_nx    = idx_q;
		len_done  = 1'b0;
		done_len  = len_q;
		push      = 1'b0;

		entry.kind           = wsfp_pkg::KindHeader;
		entry.final_fragment = fin_q;
		entry.reserved_bits  = rsv_q;
		entry.opcode         = opcode_q;
		entry.is_masked      = masked_q;
		entry.payload_length = len_q;
		entry.raw_byte       = 8'h00;
		entry.key_byte       = 8'h00;
		entry.end_of_frame   = 1'b0;

		case (phase_cur)
			PH_HDR1: begin
				masked_nx = 1'b0;
				len_nx    = '0;
				rem_nx    = '0;
				cnt_nx    = '0;
				key_nx    = '0;
				idx_nx    = '0;
				phase_nx  = PH_HDR2;
			end
			PH_HDR2: begin
				masked_nx = b[7];
				len_nx    = '0;
				if (b[6:0] == wsfp_pkg::Len7Ext64) begin
					cnt_nx   = wsfp_pkg::ExtBytes64;
					phase_nx = PH_EXTLEN;
				end else if (b[6:0] == wsfp_pkg::Len7Ext16) begin
					cnt_nx   = wsfp_pkg::ExtBytes16;
					phase_nx = PH_EXTLEN;
				end else begin
					len_nx   = {{(wsfp_pkg::LenW-7){1'b0}}, b[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_nx = ext_len;
				cnt_nx = cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					len_done = 1'b1;
				end
			end
			PH_MASK: begin
				key_nx = {key_q[23:0], b};
				cnt_nx = cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					// key complete: header goes out now
					push     = 1'b1;
					rem_nx   = len_q;
					idx_nx   = '0;
					phase_nx = (len_q == '0) ? PH_DONE : PH_PAYLOAD;
					entry.end_of_frame = (len_q == '0);
				end
			end
			PH_PAYLOAD: begin
				push           = 1'b1;
				entry.kind     = wsfp_pkg::KindPayload;
				entry.raw_byte = b;
				if (masked_q) begin
					entry.key_byte = key_q[8*(3-idx_q) +: 8];
				end
				idx_nx = idx_q + 2'd1;
				rem_nx = rem_q - {{(wsfp_pkg::LenW-1){1'b0}}, 1'b1};
				if (rem_q == {{(wsfp_pkg::LenW-1){1'b0}}, 1'b1}) begin
					entry.end_of_frame = 1'b1;
					phase_nx           = PH_DONE;
				end
			end
			default: begin
				phase_nx = PH_DONE;
			end
		endcase

		// Length known: collect the key, or emit the header right away
		if (len_done) begin
			done_len = len_nx;
			if (masked_nx) begin
				cnt_nx   = wsfp_pkg::KeyBytes;
				key_nx   = '0;
				phase_nx = PH_MASK;
			end else begin
				push     = 1'b1;
				rem_nx   = done_len;
				idx_nx   = '0;
				phase_nx = (done_len == '0) ? PH_DONE : PH_PAYLOAD;
				entry.end_of_frame = (done_len == '0);
			end
		end

		// Header beats carry the header as just completed
		if (phase_cur == PH_HDR2) begin
			entry.is_masked      = masked_nx;
			entry.payload_length = done_len;
		end
		if (phase_cur == PH_EXTLEN) begin
			entry.payload_length = done_len;
		end

		push = push & take;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			fin_q    <= 1'b0;
			rsv_q    <= '0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
		end else if (take) begin
			phase_q  <= phase_nx;
			masked_q <= masked_nx;
			len_q    <= len_nx;
			rem_q    <= rem_nx;
			cnt_q    <= cnt_nx;
			key_q    <= key_nx;
			idx_q    <= idx_nx;
			if (phase_cur == PH_HDR1) begin
				fin_q    <= b[7];
				rsv_q    <= b[6:4];
				opcode_q <= b[3:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wsfp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfp_queue #(
	parameter int unsigned DEPTH = wsfp_pkg::QueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire wsfp_pkg::entry_t wr_entry,
	input  wire logic             pop,
	output logic                  rd_valid,
	output wsfp_pkg::entry_t      rd_entry,
	output logic                  full
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
	localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
	localparam logic [CntW-1:0] CntOne  = CntW'(1);

	wsfp_pkg::entry_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == FullCnt);
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntOne;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntOne;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wsfp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_valid,
	input  wire wsfp_pkg::entry_t rd_entry,
	output logic                  pop,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output wsfp_pkg::result_t     result
);

	logic              valid_q;
	wsfp_pkg::result_t result_q;

	// Refill the output register whenever it is empty or being taken
	assign pop          = rd_valid && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !result_stall) begin
			valid_q <= rd_valid;
		end
	end

	// Unmask and format the beat
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.kind           <= rd_entry.kind;
			result_q.final_fragment <= rd_entry.final_fragment;
			result_q.reserved_bits  <= rd_entry.reserved_bits;
			result_q.opcode         <= rd_entry.opcode;
			result_q.is_masked      <= rd_entry.is_masked;
			result_q.payload_length <= rd_entry.payload_length;
			result_q.payload_byte   <= rd_entry.raw_byte ^ rd_entry.key_byte;
			result_q.end_of_frame   <= rd_entry.end_of_frame;
		end
	end

endmodule
`default_nettype wire

// ===== bench/websocket_frame_parser_unit_checker.sv =====
`timescale 1ns / 1ps
module wsfp_frame_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_stall,
	input  wire wsfp_pkg::item_t   item,
	input  wire logic              result_valid,
	input  wire logic              result_stall,
	input  wire wsfp_pkg::result_t result,
	output int unsigned            mismatches,
	output int unsigned            outstanding,
	output int unsigned            checked
);

	typedef enum logic [2:0] {
		PhHeadFirst,
		PhHeadSecond,
		PhExtLen,
		PhKey,
		PhPayload,
		PhDrop
	} frame_phase_t;

	// Parser copy kept in step with every accepted input beat
	frame_phase_t frame_phase;
	logic [8:0]   hdr_bits;    // fin, rsv[2:0], opcode[3:0], mask flag
	logic [63:0]  len_acc;
	logic [3:0]   ext_left;
	logic [31:0]  key_word;    // first key byte in the top byte
	logic [2:0]   key_left;
	logic [63:0]  bytes_left;
	logic [1:0]   key_idx;

	wsfp_pkg::result_t due_results[$];
	int unsigned       fail_tally;
	int unsigned       tally_checked;

	function automatic wsfp_pkg::result_t make_result(input logic kind,
		input logic [7:0] pbyte, input logic eof);
		wsfp_pkg::result_t r;
		r.kind           = kind;
		r.final_fragment = hdr_bits[8];
		r.reserved_bits  = hdr_bits[7:5];
		r.opcode         = hdr_bits[4:1];
		r.is_masked      = hdr_bits[0];
		r.payload_length = len_acc[wsfp_pkg::LenW-1:0];
		r.payload_byte   = pbyte;
		r.end_of_frame   = eof;
		return r;
	endfunction

	// Header complete: length top bit dropped, empty frames end right here
	function automatic wsfp_pkg::result_t close_header();
		len_acc[63] = 1'b0;
		bytes_left  = len_acc;
		key_idx     = 2'd0;
		if (bytes_left == 64'd0) begin
			frame_phase = PhDrop;
			return make_result(wsfp_pkg::KindHeader, 8'h00, 1'b1);
		end
		frame_phase = PhPayload;
		return make_result(wsfp_pkg::KindHeader, 8'h00, 1'b0);
	endfunction

	// Length known: either collect the key or close the header now
	function automatic logic end_of_length(output wsfp_pkg::result_t r);
		r = '0;
		if (hdr_bits[0]) begin
			key_left    = 3'(wsfp_pkg::KeyBytes);
			key_word    = 32'd0;
			frame_phase = PhKey;
			return 1'b0;
		end
		r = close_header();
		return 1'b1;
	endfunction

	// Advance the parser by one byte; returns 1 when the byte yields a result
	function automatic logic parse_beat(input wsfp_pkg::item_t it,
		output wsfp_pkg::result_t r);
		logic [7:0] b;
		logic [6:0] len7;
		logic [7:0] kb;
		logic       hit;
		b   = it.byte_value;
		r   = '0;
		hit = 1'b0;
		if (it.buffer_start)
			frame_phase = PhHeadFirst;
		case (frame_phase)
			PhHeadFirst: begin
				hdr_bits    = {b, 1'b0};
				len_acc     = 64'd0;
				ext_left    = 4'd0;
				key_word    = 32'd0;
				key_left    = 3'd0;
				bytes_left  = 64'd0;
				key_idx     = 2'd0;
				frame_phase = PhHeadSecond;
			end
			PhHeadSecond: begin
				hdr_bits[0] = b[7];
				len7        = b[6:0];
				len_acc     = 64'd0;
				if (len7 == wsfp_pkg::Len7Ext64) begin
					ext_left    = wsfp_pkg::ExtBytes64;
					frame_phase = PhExtLen;
				end else if (len7 == wsfp_pkg::Len7Ext16) begin
					ext_left    = wsfp_pkg::ExtBytes16;
					frame_phase = PhExtLen;
				end else begin
					len_acc = 64'(len7);
					hit     = end_of_length(r);
				end
			end
			PhExtLen: begin
				// big-endian extended length
				len_acc  = {len_acc[55:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 4'd0)
					hit = end_of_length(r);
			end
			PhKey: begin
				key_word = {key_word[23:0], b};
				key_left = key_left - 3'd1;
				if (key_left == 3'd0) begin
					r   = close_header();
					hit = 1'b1;
				end
			end
			PhPayload: begin
				kb = 8'h00;
				if (hdr_bits[0])
					kb = 8'(key_word >> (8 * (3 - key_idx)));
				key_idx    = key_idx + 2'd1;
				bytes_left = bytes_left - 64'd1;
				r   = make_result(wsfp_pkg::KindPayload, b ^ kb, bytes_left == 64'd0);
				hit = 1'b1;
				if (bytes_left == 64'd0)
					frame_phase = PhDrop;
			end
			default: begin
				// trailing bytes: dropped until the next buffer start
				frame_phase = PhDrop;
			end
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wsfp_pkg::result_t seen;
		wsfp_pkg::result_t want;
		wsfp_pkg::result_t made;
		if (!arst_n) begin
			frame_phase   = PhHeadFirst;
			hdr_bits      = 9'd0;
			len_acc       = 64'd0;
			ext_left      = 4'd0;
			key_word      = 32'd0;
			key_left      = 3'd0;
			bytes_left    = 64'd0;
			key_idx       = 2'd0;
			fail_tally    = 0;
			tally_checked = 0;
			due_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			// result beat against the oldest prediction
			if (result_valid && !result_stall) begin
				seen = result;
				if (due_results.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("%0t: result beat with nothing due: %s%0d byte=%02h eof=%0d",
							$realtime, "kind=", seen.kind, seen.payload_byte,
							seen.end_of_frame);
				end else begin
					want = due_results.pop_front();
					tally_checked++;
					if (seen !== want) begin
						fail_tally++;
						if (fail_tally <= 10) begin
							$display({"%0t: mismatch exp kind=%0d fin=%0d rsv=%0d ",
								"op=%0h msk=%0d len=%0d byte=%02h eof=%0d"},
								$realtime, want.kind, want.final_fragment,
								want.reserved_bits, want.opcode, want.is_masked,
								want.payload_length, want.payload_byte,
								want.end_of_frame);
							$display({"%0t:          got kind=%0d fin=%0d rsv=%0d ",
								"op=%0h msk=%0d len=%0d byte=%02h eof=%0d"},
								$realtime, seen.kind, seen.final_fragment,
								seen.reserved_bits, seen.opcode, seen.is_masked,
								seen.payload_length, seen.payload_byte,
								seen.end_of_frame);
						end
					end
				end
			end
			// input beat: predict what it yields
			if (item_valid && !item_stall) begin
				if (parse_beat(item, made))
					due_results.push_back(made);
			end
			mismatches  <= fail_tally;
			outstanding <= due_results.size();
			checked     <= tally_checked;
		end
	end

endmodule

// ===== bench/websocket_frame_parser_unit_tb.sv =====
`timescale 1ns / 1ps
module websocket_frame_parser_unit_tb;

	typedef enum logic [1:0] {
		LenShort,
		LenExt16,
		LenExt64
	} len_form_t;

	localparam int unsigned CutNone = 32'hFFFF_FFFF;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	wsfp_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	wsfp_pkg::result_t result;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned idle_pct    = 0;
	int unsigned stall_pct   = 0;
	int unsigned beats_sent  = 0;
	int unsigned frames_sent = 0;

	websocket_frame_parser_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	wsfp_frame_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked)
	);

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// One input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic start, input logic [7:0] value);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{byte_value: value, buffer_start: start};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	// Frame as a new buffer: header, key, payload, trailing bytes, cut after 'cut' bytes
	task automatic send_frame(input logic [7:0] first, input logic masked,
		input len_form_t form, input logic [63:0] length, input int unsigned pay_count,
		input int unsigned tail_count, input int unsigned cut);
		logic [7:0]  frame_bytes[$];
		logic [31:0] key;
		key = $urandom;
		frame_bytes.push_back(first);
		case (form)
			LenExt16: begin
				frame_bytes.push_back({masked, wsfp_pkg::Len7Ext16});
				frame_bytes.push_back(length[15:8]);
				frame_bytes.push_back(length[7:0]);
			end
			LenExt64: begin
				frame_bytes.push_back({masked, wsfp_pkg::Len7Ext64});
				for (int i = 7; i >= 0; i--)
					frame_bytes.push_back(length[i*8 +: 8]);
			end
			default: begin
				frame_bytes.push_back({masked, length[6:0]});
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				frame_bytes.push_back(key[i*8 +: 8]);
		repeat (pay_count + tail_count)
			frame_bytes.push_back(8'($urandom));
		foreach (frame_bytes[i])
			if (i < cut)
				send_beat(i == 0, frame_bytes[i]);
		frames_sent++;
	endtask

	// Mostly well-formed frames, some cut short, some noise
	task automatic send_random_frame();
		int unsigned pick;
		int unsigned plen;
		int unsigned tail;
		int unsigned size;
		int unsigned cut;
		logic [7:0]  first;
		logic        masked;
		logic [63:0] length;
		len_form_t   form;
		first  = 8'($urandom);
		masked = 1'($urandom);
		pick   = $urandom_range(99);
		if (pick < 5) begin
			// loose bytes with random buffer-start flags
			repeat ($urandom_range(4, 1))
				send_beat(1'($urandom), 8'($urandom));
		end else if (pick < 15) begin
			// wide random length, a few payload bytes, then abandoned
			if ($urandom_range(1)) begin
				form   = LenExt64;
				length = {$urandom, $urandom};
			end else begin
				form   = LenExt16;
				length = 64'($urandom_range(16'hffff));
			end
			send_frame(first, masked, form, length, $urandom_range(4), 0, CutNone);
		end else begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				form = LenShort;
				plen = $urandom_range(12);
			end else if (pick < 90) begin
				form = LenExt16;
				plen = $urandom_range(40);
			end else begin
				form = LenExt64;
				plen = $urandom_range(20);
			end
			length = 64'(plen);
			if (form == LenExt64)
				length[63] = 1'($urandom);
			tail = ($urandom_range(9) < 3) ? $urandom_range(2, 1) : 0;
			size = 2 + plen + (masked ? 4 : 0) +
				((form == LenExt16) ? 2 : (form == LenExt64) ? 8 : 0);
			cut  = ($urandom_range(99) < 18) ? $urandom_range(size - 1, 1) : CutNone;
			send_frame(first, masked, form, length, plen, tail, cut);
		end
	endtask

	initial begin
		int unsigned target;
		int unsigned drain;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero header, empty payload, then a trailing byte
		send_frame(8'h00, 1'b0, LenShort, 64'd0, 0, 1, CutNone);
		// all header bits set, masked one-byte payload
		send_frame(8'hff, 1'b1, LenShort, 64'd1, 1, 0, CutNone);
		// 16-bit extended length, unmasked pass-through
		send_frame(8'h81, 1'b0, LenExt16, 64'd1, 1, 0, CutNone);
		// 64-bit length with only its top bit set: reads as empty
		send_frame(8'h82, 1'b1, LenExt64, 64'h8000_0000_0000_0000, 0, 0, 6);
		send_frame(8'h8a, 1'b0, LenExt64, 64'h8000_0000_0000_0000, 0, 0, CutNone);
		// short buffer: next buffer start abandons this frame
		send_frame(8'h01, 1'b1, LenShort, 64'd5, 5, 0, 3);

		// random part over four idle/stall mixes
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			target = beats_sent + 100;
			while (beats_sent < target)
				send_random_frame();
		end
		item_valid <= 1'b0;

		// drain the output side, then a few more cycles
		drain = 0;
		while (outstanding != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);

		$display("Covered %0d input beats in %0d frames (clean, cut short and noise) under four",
			beats_sent, frames_sent);
		$display("idle/stall mixes; %0d result beats compared", checked);
		if (outstanding != 0)
			$display("%0d predicted result beats never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("websocket_frame_parser_unit verification clean");
		end else begin
			$display("websocket_frame_parser_unit verification failed");
		end
		$finish;
	end

	// hard stop
	initial begin
		#(2_000_000);
		$display("websocket_frame_parser_unit verification failed");
		$finish;
	end

endmodule
